FILE: hw/rtl/hjhd_pkg.sv
package hjhd_pkg;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BIAS_TIMEOUT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE         = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIC_CHECK      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOOK_DEBOUNCE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOCK_DEBOUNCE  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_INTERVAL = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_LIMIT    = 3'd6;

  localparam logic [15:0] BIAS_TIMEOUT_RESET   = 16'd1000;
  localparam logic [15:0] SETTLE_RESET         = 16'd600;
  localparam logic [15:0] MIC_CHECK_RESET      = 16'd300;
  localparam logic [15:0] HOOK_DEBOUNCE_RESET  = 16'd90;
  localparam logic [15:0] DOCK_DEBOUNCE_RESET  = 16'd65;
  localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd100;
  localparam logic [3:0]  RETRY_LIMIT_RESET    = 4'd10;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PENDING = 3'd1;
  localparam logic [2:0] PH_BIAS    = 3'd2;
  localparam logic [2:0] PH_SETTLE  = 3'd3;
  localparam logic [2:0] PH_MIC     = 3'd4;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_HEADSET  = 2'd1;
  localparam logic [1:0] KIND_EARPHONE = 2'd2;

  localparam logic [1:0] KEY_NONE    = 2'd0;
  localparam logic [1:0] KEY_PRESS   = 2'd1;
  localparam logic [1:0] KEY_RELEASE = 2'd2;

  typedef struct packed {
    logic       jack_level;
    logic       hook_level;
    logic       dock_level;
    logic       bias_ack;
    logic [1:0] hook_mute;
  } tick_t;

  typedef struct packed {
    logic [1:0] plug_kind;
    logic       plug_report;
    logic [1:0] key_event;
    logic       is_docked;
    logic       dock_report;
    logic       bias_request;
  } status_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_write_t;

endpackage

FILE: hw/rtl/hjhd_chan_if.sv
interface hjhd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/headset_jack_hook_detector.sv
// Jack, hook key and dock detector stepped by one 1 ms tick word per input.
// Every tick word yields exactly one status word. The tick state is updated by
// a single pass of logic at the accepting edge and the status word lands in
// an output register, so one word is taken every clock cycle; input ready falls
// only while the output register is full and its sink is stalled. Timers are
// TIMER_BITS wide and delays are truncated to it. Configuration writes are always
// ready and must be issued while idle.
module headset_jack_hook_detector
  import hjhd_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  hjhd_chan_if.sink   item,
  hjhd_chan_if.source result,
  hjhd_chan_if.sink   cfg
);

  typedef logic [TIMER_BITS-1:0] timer_t;

  logic [15:0] bias_timeout_ticks;
  logic [15:0] settle_ticks;
  logic [15:0] mic_check_ticks;
  logic [15:0] hook_debounce_ticks;
  logic [15:0] dock_debounce_ticks;
  logic [15:0] retry_interval_ticks;
  logic [3:0]  retry_limit;

  logic [2:0] detect_phase, detect_phase_next;
  timer_t     detect_timer, detect_timer_next;
  logic [1:0] kind_reg, kind_reg_next;
  logic [3:0] retries_left, retries_left_next;
  logic       jack_arm_level, jack_arm_level_next;
  logic       jack_armed, jack_armed_next;
  logic       hook_armed, hook_armed_next;
  logic       hook_arm_level, hook_arm_level_next;
  timer_t     hook_timer, hook_timer_next;
  logic       key_down, key_down_next;
  logic       dock_arm_level, dock_arm_level_next;
  timer_t     dock_timer, dock_timer_next;
  logic       docked_reg, docked_reg_next;
  logic       bias_reg, bias_reg_next;
  logic       rerun_req, rerun_req_next;
  logic       hook_pending, hook_pending_next;
  logic       dock_pending, dock_pending_next;

  logic    out_valid;
  status_t out_word;
  status_t status_next;
  tick_t   tick;
  logic    accept;

  function automatic timer_t load_delay(input logic [15:0] v);
    return timer_t'(v);
  endfunction

  function automatic logic job_busy(input logic [2:0] ph);
    return (ph == PH_BIAS) || (ph == PH_SETTLE) || (ph == PH_MIC);
  endfunction

  assign tick          = item.payload;
  assign item.ready    = !out_valid || result.ready;
  assign accept        = item.valid && item.ready;
  assign result.valid  = out_valid;
  assign result.payload = out_word;
  assign cfg.ready     = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_timeout_ticks   <= BIAS_TIMEOUT_RESET;
      settle_ticks         <= SETTLE_RESET;
      mic_check_ticks      <= MIC_CHECK_RESET;
      hook_debounce_ticks  <= HOOK_DEBOUNCE_RESET;
      dock_debounce_ticks  <= DOCK_DEBOUNCE_RESET;
      retry_interval_ticks <= RETRY_INTERVAL_RESET;
      retry_limit          <= RETRY_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        REG_BIAS_TIMEOUT:   bias_timeout_ticks   <= cfg.payload.data;
        REG_SETTLE:         settle_ticks         <= cfg.payload.data;
        REG_MIC_CHECK:      mic_check_ticks      <= cfg.payload.data;
        REG_HOOK_DEBOUNCE:  hook_debounce_ticks  <= cfg.payload.data;
        REG_DOCK_DEBOUNCE:  dock_debounce_ticks  <= cfg.payload.data;
        REG_RETRY_INTERVAL: retry_interval_ticks <= cfg.payload.data;
        REG_RETRY_LIMIT:    retry_limit          <= cfg.payload.data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic       plug_rep;
    logic [1:0] key;
    logic       dock_rep;
    logic       retry;
    logic       finish;

    detect_phase_next   = detect_phase;
    detect_timer_next   = detect_timer;
    kind_reg_next       = kind_reg;
    retries_left_next   = retries_left;
    jack_arm_level_next = jack_arm_level;
    jack_armed_next     = jack_armed;
    hook_armed_next     = hook_armed;
    hook_arm_level_next = hook_arm_level;
    hook_timer_next     = hook_timer;
    key_down_next       = key_down;
    dock_arm_level_next = dock_arm_level;
    dock_timer_next     = dock_timer;
    docked_reg_next     = docked_reg;
    bias_reg_next       = bias_reg;
    rerun_req_next      = rerun_req;
    hook_pending_next   = hook_pending;
    dock_pending_next   = dock_pending;
    plug_rep = 1'b0;
    key      = KEY_NONE;
    dock_rep = 1'b0;
    retry    = 1'b0;
    finish   = 1'b0;

    // triggers
    if (jack_armed && (tick.jack_level == jack_arm_level)) begin
      jack_armed_next = 1'b0;
      if (detect_phase == PH_PENDING) begin
      end else if (job_busy(detect_phase)) begin
        rerun_req_next = 1'b1;
      end else begin
        detect_phase_next = PH_PENDING;
        detect_timer_next = '0;
      end
    end
    if (hook_armed && (tick.hook_level == hook_arm_level)) begin
      hook_armed_next = 1'b0;
      if (!hook_pending) begin
        hook_pending_next = 1'b1;
        hook_timer_next   = load_delay(hook_debounce_ticks);
      end
    end
    if (!dock_pending && (tick.dock_level == dock_arm_level)) begin
      dock_pending_next = 1'b1;
      dock_timer_next   = load_delay(dock_debounce_ticks);
    end

    // detection sequence
    case (detect_phase_next)
      PH_PENDING: begin
        if (detect_timer_next != '0) begin
          detect_timer_next = detect_timer_next - 1'b1;
        end else if (!tick.jack_level) begin
          bias_reg_next     = 1'b1;
          detect_phase_next = PH_BIAS;
          detect_timer_next = load_delay(bias_timeout_ticks);
        end else begin
          // removal
          bias_reg_next = 1'b0;
          if (kind_reg_next == KIND_HEADSET) begin
            if (key_down_next) begin
              key           = KEY_RELEASE;
              key_down_next = 1'b0;
            end
            hook_armed_next = 1'b0;
          end
          kind_reg_next       = KIND_NONE;
          jack_arm_level_next = 1'b0;
          retries_left_next   = retry_limit;
          finish              = 1'b1;
        end
      end
      PH_BIAS: begin
        if (tick.bias_ack || (detect_timer_next == '0)) begin
          detect_phase_next = PH_SETTLE;
          detect_timer_next = load_delay(settle_ticks);
        end else begin
          detect_timer_next = detect_timer_next - 1'b1;
        end
      end
      PH_SETTLE: begin
        if (detect_timer_next != '0) begin
          detect_timer_next = detect_timer_next - 1'b1;
        end else if (tick.jack_level) begin
          finish = 1'b1;
        end else if (tick.hook_level) begin
          retry         = (retries_left_next != 4'd0);
          kind_reg_next = KIND_EARPHONE;
          if (retry) begin
            retries_left_next = retries_left_next - 4'd1;
          end
          jack_arm_level_next = 1'b1;
          finish              = 1'b1;
        end else begin
          detect_phase_next = PH_MIC;
          detect_timer_next = load_delay(mic_check_ticks);
        end
      end
      PH_MIC: begin
        if (detect_timer_next != '0) begin
          detect_timer_next = detect_timer_next - 1'b1;
        end else if (tick.jack_level) begin
          finish = 1'b1;
        end else begin
          kind_reg_next       = KIND_HEADSET;
          hook_arm_level_next = 1'b1;
          hook_armed_next     = 1'b1;
          jack_arm_level_next = 1'b1;
          finish              = 1'b1;
        end
      end
      default: begin
        detect_phase_next = PH_IDLE;
      end
    endcase

    // job end
    if (finish) begin
      jack_armed_next = 1'b1;
      plug_rep        = 1'b1;
      if (rerun_req_next) begin
        rerun_req_next    = 1'b0;
        detect_phase_next = PH_PENDING;
        detect_timer_next = '0;
      end else if (retry) begin
        detect_phase_next = PH_PENDING;
        detect_timer_next = load_delay(retry_interval_ticks);
      end else begin
        detect_phase_next = PH_IDLE;
        detect_timer_next = '0;
      end
    end

    // hook action
    if (hook_pending_next) begin
      if (hook_timer_next != '0) begin
        hook_timer_next = hook_timer_next - 1'b1;
      end else if (!job_busy(detect_phase_next)) begin
        hook_pending_next = 1'b0;
        if ((tick.hook_mute == 2'd0) && (kind_reg_next == KIND_HEADSET)) begin
          if (tick.hook_level) begin
            if (!key_down_next) begin
              key = KEY_PRESS;
            end
            key_down_next       = 1'b1;
            hook_arm_level_next = 1'b0;
          end else if (key_down_next) begin
            key                 = KEY_RELEASE;
            key_down_next       = 1'b0;
            hook_arm_level_next = 1'b1;
          end
          hook_armed_next = 1'b1;
        end
      end
    end

    // dock action
    if (dock_pending_next) begin
      if (dock_timer_next != '0) begin
        dock_timer_next = dock_timer_next - 1'b1;
      end else if (!job_busy(detect_phase_next)) begin
        dock_pending_next   = 1'b0;
        docked_reg_next     = !tick.dock_level;
        dock_arm_level_next = !tick.dock_level;
        dock_rep            = 1'b1;
      end
    end

    status_next.plug_kind    = kind_reg_next;
    status_next.plug_report  = plug_rep;
    status_next.key_event    = key;
    status_next.is_docked    = docked_reg_next;
    status_next.dock_report  = dock_rep;
    status_next.bias_request = bias_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_phase   <= PH_IDLE;
      detect_timer   <= '0;
      kind_reg       <= KIND_NONE;
      retries_left   <= RETRY_LIMIT_RESET;
      jack_arm_level <= 1'b0;
      jack_armed     <= 1'b1;
      hook_armed     <= 1'b0;
      hook_arm_level <= 1'b1;
      hook_timer     <= '0;
      key_down       <= 1'b0;
      dock_arm_level <= 1'b0;
      dock_timer     <= '0;
      docked_reg     <= 1'b0;
      bias_reg       <= 1'b0;
      rerun_req      <= 1'b0;
      hook_pending   <= 1'b0;
      dock_pending   <= 1'b0;
    end else if (accept) begin
      detect_phase   <= detect_phase_next;
      detect_timer   <= detect_timer_next;
      kind_reg       <= kind_reg_next;
      retries_left   <= retries_left_next;
      jack_arm_level <= jack_arm_level_next;
      jack_armed     <= jack_armed_next;
      hook_armed     <= hook_armed_next;
      hook_arm_level <= hook_arm_level_next;
      hook_timer     <= hook_timer_next;
      key_down       <= key_down_next;
      dock_arm_level <= dock_arm_level_next;
      dock_timer     <= dock_timer_next;
      docked_reg     <= docked_reg_next;
      bias_reg       <= bias_reg_next;
      rerun_req      <= rerun_req_next;
      hook_pending   <= hook_pending_next;
      dock_pending   <= dock_pending_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= status_next;
    end
  end

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word did not reach the output register");

  a_kind_needs_bias: assert property (@(posedge clk) disable iff (rst)
    (kind_reg != KIND_NONE) |-> bias_reg)
    else $error("plug classified without mic bias");

  a_hook_timer_idle: assert property (@(posedge clk) disable iff (rst)
    !hook_pending |-> (hook_timer == '0))
    else $error("hook timer running without a pending hook action");

  a_dock_timer_idle: assert property (@(posedge clk) disable iff (rst)
    !dock_pending |-> (dock_timer == '0))
    else $error("dock timer running without a pending dock action");

endmodule
